/* src/rtree_node_branch_table_macros.svh */
// Assertion macros for the R-tree node branch table
`ifndef RTREE_NODE_BRANCH_TABLE_MACROS_SVH
`define RTREE_NODE_BRANCH_TABLE_MACROS_SVH

// same-cycle implication
`define RNTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RNTB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rntb_pkg.sv */
// Shared types and codes for the R-tree node branch table
`default_nettype none
package rntb_pkg;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_PICK   = 2'd2;
    localparam logic [1:0] KIND_COVER  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BADSLOT = 2'd2;

    typedef struct packed {
        logic load_q;
        logic start_scan;
        logic scan_step;
        logic load_imm;
        logic load_scan;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic scan_last;
    } sts_t;

endpackage
`default_nettype wire

/* src/rntb_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module rntb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/rntb_ctrl.sv */
// Controller state machine for the R-tree node branch table
`default_nettype none
module rntb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     kind,
    output logic                out_valid,
    input  wire logic           out_stall,
    output rntb_pkg::cmd_t      cmd,
    input  wire rntb_pkg::sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, take, imm_kind;

    assign imm_kind  = (kind == rntb_pkg::KIND_ADD) || (kind == rntb_pkg::KIND_REMOVE);
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall && imm_kind);
    assign accept    = in_valid && !in_stall;
    assign take      = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_q = 1'b1;
                    if (imm_kind)
                    begin
                        cmd.load_imm = 1'b1;
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || take)
                begin
                    cmd.load_scan = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_imm || cmd.load_scan)
        begin
            out_valid_next = 1'b1;
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* src/rntb_datapath.sv */
// Datapath: slot store, volume pipeline, pick and cover reduction, result register
`default_nettype none
module rntb_datapath #(
    parameter int SLOTS      = 8,
    parameter int COORD_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rntb_pkg::cmd_t cmd,
    output rntb_pkg::sts_t      sts,
    input  wire logic [1:0]     kind,
    input  wire logic [2:0]     slot,
    input  wire logic [15:0]    child_id,
    input  wire logic [15:0]    box_min_x,
    input  wire logic [15:0]    box_min_y,
    input  wire logic [15:0]    box_min_z,
    input  wire logic [15:0]    box_max_x,
    input  wire logic [15:0]    box_max_y,
    input  wire logic [15:0]    box_max_z,
    output logic [1:0]          status,
    output logic [2:0]          chosen_slot,
    output logic [3:0]          entry_count,
    output logic                cover_empty,
    output logic [15:0]         cover_min_x,
    output logic [15:0]         cover_min_y,
    output logic [15:0]         cover_min_z,
    output logic [15:0]         cover_max_x,
    output logic [15:0]         cover_max_y,
    output logic [15:0]         cover_max_z
);

    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS;
    localparam int VW = 3 * EW;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = 16 + 6 * CB;

    function automatic logic [EW-1:0] extent(input logic signed [CB-1:0] lo,
                                             input logic signed [CB-1:0] hi);
        logic signed [CB:0] d;
        d = {hi[CB-1], hi} - {lo[CB-1], lo};
        extent = d[CB] ? '0 : d[EW-1:0];
    endfunction

    function automatic logic [15:0] to_field(input logic signed [CB-1:0] v);
        logic [31:0] w;
        w = {{(32 - CB){v[CB-1]}}, v};
        to_field = w[15:0];
    endfunction

    // node state
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    count_reg, count_next;

    // query
    logic [1:0]             kind_reg;
    logic signed [CB-1:0]   q_lo_reg [3];
    logic signed [CB-1:0]   q_hi_reg [3];

    // add / remove decode
    logic          full;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] rm_idx;
    logic          rm_ok;
    logic          add_we;
    logic [RW-1:0] wdata;

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
            end
        end
    end

    assign full   = &valid_reg;
    assign rm_idx = SW'(slot);
    assign rm_ok  = (32'(slot) < SLOTS) && valid_reg[rm_idx];
    assign add_we = cmd.load_imm && (kind == rntb_pkg::KIND_ADD) && !full;
    assign wdata  = {child_id,
                     box_min_x[CB-1:0], box_min_y[CB-1:0], box_min_z[CB-1:0],
                     box_max_x[CB-1:0], box_max_y[CB-1:0], box_max_z[CB-1:0]};

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (add_we)
        begin
            valid_next[free_idx] = 1'b1;
            count_next           = count_reg + CW'(1);
        end
        else if (cmd.load_imm && (kind == rntb_pkg::KIND_REMOVE) && rm_ok)
        begin
            valid_next[rm_idx] = 1'b0;
            count_next         = count_reg - CW'(1);
        end
    end

    // scan issue
    logic [SW-1:0] scan_idx_reg;
    logic [RW-1:0] rdata;

    rntb_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (add_we),
        .waddr (free_idx),
        .wdata (wdata),
        .raddr (scan_idx_reg),
        .rdata (rdata)
    );

    assign sts.scan_last = (32'(scan_idx_reg) == SLOTS - 1);

    // pipeline tags
    logic          t1_act, t2_act, t3_act, t4_act, t5_act;
    logic [SW-1:0] t1_idx, t2_idx, t3_idx, t4_idx, t5_idx;

    assign sts.busy = t1_act || t2_act || t3_act || t4_act || t5_act;

    // stage 1: extents of slot box and merged box
    logic signed [CB-1:0] s_lo [3];
    logic signed [CB-1:0] s_hi [3];
    logic signed [CB-1:0] m_lo [3];
    logic signed [CB-1:0] m_hi [3];
    logic [EW-1:0]        ex2_reg [3];
    logic [EW-1:0]        mx2_reg [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s_lo[a] = rdata[(6 - a) * CB - 1 -: CB];
            s_hi[a] = rdata[(3 - a) * CB - 1 -: CB];
            m_lo[a] = (q_lo_reg[a] < s_lo[a]) ? q_lo_reg[a] : s_lo[a];
            m_hi[a] = (q_hi_reg[a] > s_hi[a]) ? q_hi_reg[a] : s_hi[a];
        end
    end

    // stages 2..4: volume products
    logic [2*EW-1:0] pv3_reg, pm3_reg;
    logic [EW-1:0]   ez3_reg, mz3_reg;
    logic [2*EW-1:0] vl4_reg, vh4_reg, ml4_reg, mh4_reg;
    logic [VW-1:0]   vol5_reg, mvol5_reg;

    // stage 5: best choice
    logic          best_have_reg;
    logic [VW-1:0] best_inc_reg, best_vol_reg;
    logic [SW-1:0] best_idx_reg;
    logic [VW-1:0] inc5;
    logic          better;

    assign inc5   = mvol5_reg - vol5_reg;
    assign better = !best_have_reg || (inc5 < best_inc_reg) ||
                    ((inc5 == best_inc_reg) && (vol5_reg < best_vol_reg));

    // cover accumulation
    logic                 cov_have_reg;
    logic signed [CB-1:0] cov_lo_reg [3];
    logic signed [CB-1:0] cov_hi_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            t1_act        <= 1'b0;
            t2_act        <= 1'b0;
            t3_act        <= 1'b0;
            t4_act        <= 1'b0;
            t5_act        <= 1'b0;
            best_have_reg <= 1'b0;
            cov_have_reg  <= 1'b0;
            scan_idx_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            t1_act    <= cmd.scan_step && valid_reg[scan_idx_reg];
            t2_act    <= t1_act;
            t3_act    <= t2_act;
            t4_act    <= t3_act;
            t5_act    <= t4_act;
            if (cmd.start_scan)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_step && !sts.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
            end
            if (cmd.start_scan)
            begin
                best_have_reg <= 1'b0;
            end
            else if (t5_act && better)
            begin
                best_have_reg <= 1'b1;
            end
            if (cmd.start_scan)
            begin
                cov_have_reg <= 1'b0;
            end
            else if (t1_act)
            begin
                cov_have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            kind_reg    <= kind;
            q_lo_reg[0] <= box_min_x[CB-1:0];
            q_lo_reg[1] <= box_min_y[CB-1:0];
            q_lo_reg[2] <= box_min_z[CB-1:0];
            q_hi_reg[0] <= box_max_x[CB-1:0];
            q_hi_reg[1] <= box_max_y[CB-1:0];
            q_hi_reg[2] <= box_max_z[CB-1:0];
        end
        t1_idx <= scan_idx_reg;
        t2_idx <= t1_idx;
        t3_idx <= t2_idx;
        t4_idx <= t3_idx;
        t5_idx <= t4_idx;
        for (int a = 0; a < 3; a++)
        begin
            ex2_reg[a] <= extent(s_lo[a], s_hi[a]);
            mx2_reg[a] <= extent(m_lo[a], m_hi[a]);
            if (t1_act)
            begin
                if (!cov_have_reg || (s_lo[a] < cov_lo_reg[a]))
                begin
                    cov_lo_reg[a] <= s_lo[a];
                end
                if (!cov_have_reg || (s_hi[a] > cov_hi_reg[a]))
                begin
                    cov_hi_reg[a] <= s_hi[a];
                end
            end
        end
        pv3_reg   <= ex2_reg[0] * ex2_reg[1];
        pm3_reg   <= mx2_reg[0] * mx2_reg[1];
        ez3_reg   <= ex2_reg[2];
        mz3_reg   <= mx2_reg[2];
        vl4_reg   <= pv3_reg[EW-1:0] * ez3_reg;
        vh4_reg   <= pv3_reg[2*EW-1:EW] * ez3_reg;
        ml4_reg   <= pm3_reg[EW-1:0] * mz3_reg;
        mh4_reg   <= pm3_reg[2*EW-1:EW] * mz3_reg;
        vol5_reg  <= VW'(vl4_reg) + (VW'(vh4_reg) << EW);
        mvol5_reg <= VW'(ml4_reg) + (VW'(mh4_reg) << EW);
        if (t5_act && better)
        begin
            best_inc_reg <= inc5;
            best_vol_reg <= vol5_reg;
            best_idx_reg <= t5_idx;
        end
    end

    // result register
    logic [1:0]  status_reg;
    logic [2:0]  chosen_reg;
    logic        empty_reg;
    logic [15:0] cmin_reg [3];
    logic [15:0] cmax_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.load_imm)
        begin
            empty_reg  <= 1'b0;
            status_reg <= rntb_pkg::STATUS_OK;
            chosen_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                cmin_reg[a] <= '0;
                cmax_reg[a] <= '0;
            end
            if (kind == rntb_pkg::KIND_ADD)
            begin
                if (full)
                begin
                    status_reg <= rntb_pkg::STATUS_FULL;
                end
                else
                begin
                    chosen_reg <= 3'(free_idx);
                end
            end
            else if (!rm_ok)
            begin
                status_reg <= rntb_pkg::STATUS_BADSLOT;
            end
        end
        else if (cmd.load_scan)
        begin
            status_reg <= rntb_pkg::STATUS_OK;
            chosen_reg <= '0;
            empty_reg  <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                cmin_reg[a] <= '0;
                cmax_reg[a] <= '0;
            end
            if (kind_reg == rntb_pkg::KIND_PICK)
            begin
                if (best_have_reg)
                begin
                    chosen_reg <= 3'(best_idx_reg);
                end
            end
            else if (!cov_have_reg)
            begin
                empty_reg <= 1'b1;
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cmin_reg[a] <= to_field(cov_lo_reg[a]);
                    cmax_reg[a] <= to_field(cov_hi_reg[a]);
                end
            end
        end
    end

    assign status      = status_reg;
    assign chosen_slot = chosen_reg;
    assign entry_count = 4'(count_reg);
    assign cover_empty = empty_reg;
    assign cover_min_x = cmin_reg[0];
    assign cover_min_y = cmin_reg[1];
    assign cover_min_z = cmin_reg[2];
    assign cover_max_x = cmax_reg[0];
    assign cover_max_y = cmax_reg[1];
    assign cover_max_z = cmax_reg[2];

endmodule
`default_nettype wire

/* src/rtree_node_branch_table.sv */
// Top level of the R-tree node branch table
// Add and remove: result registered in the cycle after the item is taken; one item per cycle
//   while the output is not stalled. Pick and cover: one slot read from the slot RAM per cycle
//   feeds an extent and volume pipeline, which drains sooner when the last slots are empty;
//   then the result is registered, and no new item is taken before that.
// rst_n (asynchronous, active low) clears all valid marks, the count and the controller;
//   slot contents stay undefined until written.
`default_nettype none
`include "rtree_node_branch_table_macros.svh"
module rtree_node_branch_table #(
    parameter int SLOTS      = 8,
    parameter int COORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [2:0]  slot,
    input  wire logic [15:0] child_id,
    input  wire logic [15:0] box_min_x,
    input  wire logic [15:0] box_min_y,
    input  wire logic [15:0] box_min_z,
    input  wire logic [15:0] box_max_x,
    input  wire logic [15:0] box_max_y,
    input  wire logic [15:0] box_max_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [2:0]       chosen_slot,
    output logic [3:0]       entry_count,
    output logic             cover_empty,
    output logic [15:0]      cover_min_x,
    output logic [15:0]      cover_min_y,
    output logic [15:0]      cover_min_z,
    output logic [15:0]      cover_max_x,
    output logic [15:0]      cover_max_y,
    output logic [15:0]      cover_max_z
);

    rntb_pkg::cmd_t cmd;
    rntb_pkg::sts_t sts;

    rntb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rntb_datapath #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .slot        (slot),
        .child_id    (child_id),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .status      (status),
        .chosen_slot (chosen_slot),
        .entry_count (entry_count),
        .cover_empty (cover_empty),
        .cover_min_x (cover_min_x),
        .cover_min_y (cover_min_y),
        .cover_min_z (cover_min_z),
        .cover_max_x (cover_max_x),
        .cover_max_y (cover_max_y),
        .cover_max_z (cover_max_z)
    );

    `RNTB_ASSERT_IMP(a_full_count, out_valid && (status == rntb_pkg::STATUS_FULL), entry_count == 4'(SLOTS), "full reported with free slots")
    `RNTB_ASSERT_IMP(a_err_slot, out_valid && (status != rntb_pkg::STATUS_OK), chosen_slot == 3'd0, "error item carries a slot")
    `RNTB_ASSERT_IMP(a_empty_box, out_valid && cover_empty, (cover_min_x == 16'd0) && (cover_max_x == 16'd0), "empty cover has a box")
    `RNTB_ASSERT_NXT(a_scan_busy, in_valid && !in_stall && (kind == rntb_pkg::KIND_PICK), in_stall, "pick did not start a scan")

endmodule
`default_nettype wire
